### hdl/sesl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo end point / slew limiter package
// Shared types, register map, reset values and fixed arithmetic widths.
// ----------------------------------------------------------------------------
package sesl_pkg;

  // Default block parameters
  localparam int FULL_SCALE_DEF = 10000;
  localparam int HARD_LIMIT_DEF = 18000;

  // Slew rate divisors: per minute and per hundred milliseconds
  localparam int RATE_DIV_MIN = 60;
  localparam int RATE_DIV_PCT = 100;

  // Working widths, sized for FULL_SCALE up to 16384 and HARD_LIMIT up to 32767
  localparam int POS_W  = 32;  // scaled position plus subtrim, signed
  localparam int MAG_W  = 31;  // magnitude of end point product, up to 2^30
  localparam int RV_W   = 22;  // FULL_SCALE * speed
  localparam int RB_W   = 17;  // FULL_SCALE * speed / 60
  localparam int WIDE_W = 33;  // rate base * elapsed
  localparam int RATE_W = 26;  // final slew step per item
  localparam int R100_W = 27;  // reciprocal of 100 at WIDE_W fraction bits

  // Reciprocals for constant division (estimate, then one correction step)
  localparam logic [RB_W-1:0]   RECIP_DIV_MIN = RB_W'((64'd1 << RV_W) / RATE_DIV_MIN);
  localparam logic [R100_W-1:0] RECIP_DIV_PCT = R100_W'((64'd1 << WIDE_W) / RATE_DIV_PCT);

  // Front pipeline depth and the depths of the middle and result queues
  localparam int FRONT_STAGES = 8;
  localparam int MID_DEPTH    = 16;
  localparam int OUT_DEPTH    = 2;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SUBTRIM       = 3'd0,
    REG_ENDPOINT_LOW  = 3'd1,
    REG_ENDPOINT_HIGH = 3'd2,
    REG_SPEED         = 3'd3,
    REG_LIMIT_LOW     = 3'd4,
    REG_LIMIT_HIGH    = 3'd5,
    REG_FAILSAFE_POS  = 3'd6,
    REG_INVERT_EN     = 3'd7
  } sesl_reg_t;

  typedef struct packed {
    logic signed [15:0] subtrim;
    logic signed [15:0] endpoint_low;
    logic        [14:0] endpoint_high;
    logic        [7:0]  speed;
    logic signed [15:0] limit_low;
    logic signed [15:0] limit_high;
    logic signed [15:0] failsafe_pos;
    logic               invert_en;
  } sesl_cfg_t;

  localparam sesl_cfg_t CFG_RESET = '{
    subtrim:       16'sd0,
    endpoint_low:  -16'sd10000,
    endpoint_high: 15'd10000,
    speed:         8'd0,
    limit_low:     -16'sd15000,
    limit_high:    16'sd15000,
    failsafe_pos:  16'sd0,
    invert_en:     1'b0
  };

  // Input word
  typedef struct packed {
    logic signed [15:0] channel_in;
    logic        [15:0] gap_ms;
  } sesl_in_t;

  // Result word
  typedef struct packed {
    logic signed [15:0] servo_out;
    logic signed [15:0] failsafe_out;
  } sesl_out_t;

  // Word passed from the front to the back
  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic        [RATE_W-1:0] rate;
  } sesl_mid_t;

endpackage
`default_nettype wire

### hdl/sesl_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo end point / slew limiter queue
// Small register queue with count, used between front/back and at the output.
// ----------------------------------------------------------------------------
module sesl_fifo #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty,
  output logic                  full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

### hdl/sesl_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo end point / slew limiter front end
// Accepts items, scales by the end points and computes the slew step in an
// eight stage pipeline; holds credits for the queue that follows.
// ----------------------------------------------------------------------------
module sesl_front
  import sesl_pkg::*;
#(
  parameter int FULL_SCALE = FULL_SCALE_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire sesl_in_t  in_data,
  input  wire sesl_cfg_t cfg,
  input  wire logic      mid_pop,
  output logic           full,
  output logic           mid_push,
  output sesl_mid_t      mid_data
);

  localparam int CNT_W = $clog2(MID_DEPTH + 1);
  localparam logic [14:0]      FS_W     = 15'(FULL_SCALE);
  localparam logic [MAG_W:0]   RECIP_FS = (MAG_W + 1)'((64'd1 << MAG_W) / FULL_SCALE);

  logic                    accept;
  logic [FRONT_STAGES-1:0] vld_r, vld_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;

  // Stage registers
  logic [POS_W-1:0]  prod1_r, prod1_nxt;
  logic              xneg1_r;
  logic [RV_W-1:0]   rv1_r, rv1_nxt;
  logic [15:0]       el1_r, el2_r, el3_r, el4_r;

  logic [MAG_W-1:0]  mag2_r, mag2_nxt, mag3_r, mag4_r;
  logic              negf2_r, negf2_nxt, negf3_r, negf4_r, negf5_r;
  logic [RV_W-1:0]   rv2_r, rv3_r;
  logic [RB_W-1:0]   re2_r, re2_nxt, re3_r;

  logic [MAG_W-1:0]  qe3_r, qe3_nxt, qe4_r;
  logic [RV_W-1:0]   pr3_r, pr3_nxt;

  logic [MAG_W-1:0]  qp4_r, qp4_nxt;
  logic [RB_W-1:0]   rb4_r, rb4_nxt;

  logic [MAG_W-1:0]  q5_r, q5_nxt;
  logic [WIDE_W-1:0] w5_r, w5_nxt, w6_r, w7_r;

  logic [POS_W-1:0]  pos6_r, pos6_nxt, pos7_r, pos8_r;
  logic [RATE_W-1:0] est6_r, est6_nxt, est7_r;

  logic [WIDE_W-1:0] p7_r, p7_nxt;
  logic [RATE_W-1:0] rate8_r, rate8_nxt;

  // Intermediate products
  logic signed [16:0] ep17, x17;
  logic signed [33:0] prod_full;
  logic [22:0]        rv_full;
  logic [POS_W-1:0]   neg_p;
  logic [RV_W+RB_W-1:0] re_full;
  logic [2*MAG_W:0]   mq_full;
  logic [22:0]        pr_full;
  logic [45:0]        qp_full;
  logic [RV_W-1:0]    rv_rem;
  logic [MAG_W-1:0]   mag_rem;
  logic [WIDE_W-1:0]  w_full;
  logic [POS_W-1:0]   q_signed;
  logic [WIDE_W+R100_W-1:0] est_full;
  logic [WIDE_W-1:0]  pct_rem;

  assign full     = (cnt_r == CNT_W'(MID_DEPTH));
  assign accept   = push && !full;
  assign mid_push = vld_r[FRONT_STAGES-1];
  assign mid_data = '{pos: $signed(pos8_r), rate: rate8_r};

  // Track items in the pipeline plus the queue
  always_comb begin
    vld_nxt = {vld_r[FRONT_STAGES-2:0], accept};
    unique case ({accept, mid_pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      cnt_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Datapath per stage
  always_comb begin
    // Pick end point by sign and multiply; form FULL_SCALE * speed
    ep17      = in_data.channel_in[15] ? {cfg.endpoint_low[15], cfg.endpoint_low}
                                       : {2'b00, cfg.endpoint_high};
    x17       = {in_data.channel_in[15], in_data.channel_in};
    prod_full = ep17 * x17;
    prod1_nxt = prod_full[POS_W-1:0];
    rv_full   = 23'(FS_W) * 23'(cfg.speed);
    rv1_nxt   = rv_full[RV_W-1:0];

    // Take magnitude; estimate speed term over 60
    neg_p     = POS_W'(0) - prod1_r;
    mag2_nxt  = prod1_r[POS_W-1] ? neg_p[MAG_W-1:0] : prod1_r[MAG_W-1:0];
    negf2_nxt = prod1_r[POS_W-1] ^ xneg1_r;
    re_full   = (RV_W + RB_W)'(rv1_r) * (RV_W + RB_W)'(RECIP_DIV_MIN);
    re2_nxt   = re_full[RV_W+RB_W-1:RV_W];

    // Estimate magnitude over FULL_SCALE; back-multiply the 60 estimate
    mq_full   = (2 * MAG_W + 1)'(mag2_r) * (2 * MAG_W + 1)'(RECIP_FS);
    qe3_nxt   = mq_full[2*MAG_W-1:MAG_W];
    pr_full   = 23'(re2_r) * 23'(RATE_DIV_MIN);
    pr3_nxt   = pr_full[RV_W-1:0];

    // Back-multiply the FULL_SCALE estimate; correct the 60 quotient
    qp_full   = 46'(qe3_r) * 46'(FS_W);
    qp4_nxt   = qp_full[MAG_W-1:0];
    rv_rem    = rv3_r - pr3_r;
    rb4_nxt   = re3_r + RB_W'(rv_rem >= RV_W'(RATE_DIV_MIN));

    // Correct the FULL_SCALE quotient; rate base times elapsed
    mag_rem   = mag4_r - qp4_r;
    q5_nxt    = qe4_r + MAG_W'(mag_rem >= MAG_W'(FULL_SCALE));
    w_full    = WIDE_W'(rb4_r) * WIDE_W'(el4_r);
    w5_nxt    = w_full;

    // Restore sign, add subtrim; estimate over 100
    q_signed  = negf5_r ? POS_W'(0) - {1'b0, q5_r} : {1'b0, q5_r};
    pos6_nxt  = q_signed + {{(POS_W - 16){cfg.subtrim[15]}}, cfg.subtrim};
    est_full  = (WIDE_W + R100_W)'(w5_r) * (WIDE_W + R100_W)'(RECIP_DIV_PCT);
    est6_nxt  = est_full[WIDE_W+RATE_W-1:WIDE_W];

    // Back-multiply the 100 estimate
    p7_nxt    = WIDE_W'(est6_r) * WIDE_W'(RATE_DIV_PCT);

    // Correct the 100 quotient
    pct_rem   = w7_r - p7_r;
    rate8_nxt = est7_r + RATE_W'(pct_rem >= WIDE_W'(RATE_DIV_PCT));
  end

  // Advance payload every cycle
  always_ff @(posedge clk) begin
    prod1_r <= prod1_nxt;
    xneg1_r <= in_data.channel_in[15];
    rv1_r   <= rv1_nxt;
    el1_r   <= in_data.gap_ms;

    mag2_r  <= mag2_nxt;
    negf2_r <= negf2_nxt;
    rv2_r   <= rv1_r;
    re2_r   <= re2_nxt;
    el2_r   <= el1_r;

    qe3_r   <= qe3_nxt;
    mag3_r  <= mag2_r;
    negf3_r <= negf2_r;
    pr3_r   <= pr3_nxt;
    rv3_r   <= rv2_r;
    re3_r   <= re2_r;
    el3_r   <= el2_r;

    qp4_r   <= qp4_nxt;
    qe4_r   <= qe3_r;
    mag4_r  <= mag3_r;
    negf4_r <= negf3_r;
    rb4_r   <= rb4_nxt;
    el4_r   <= el3_r;

    q5_r    <= q5_nxt;
    negf5_r <= negf4_r;
    w5_r    <= w5_nxt;

    pos6_r  <= pos6_nxt;
    est6_r  <= est6_nxt;
    w6_r    <= w5_r;

    pos7_r  <= pos6_r;
    est7_r  <= est6_r;
    w7_r    <= w6_r;
    p7_r    <= p7_nxt;

    pos8_r  <= pos7_r;
    rate8_r <= rate8_nxt;
  end

endmodule
`default_nettype wire

### hdl/sesl_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo end point / slew limiter back end
// Applies the slew step against the previous position, clamps, inverts and
// forms the failsafe value; holds the previous position.
// ----------------------------------------------------------------------------
module sesl_back
  import sesl_pkg::*;
#(
  parameter int HARD_LIMIT = HARD_LIMIT_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      take,
  input  wire sesl_mid_t mid_data,
  input  wire sesl_cfg_t cfg,
  output sesl_out_t      out_data
);

  localparam logic signed [POS_W:0] HL_P   = (POS_W + 1)'(HARD_LIMIT);
  localparam logic signed [POS_W:0] HL_N   = -HL_P;
  localparam logic signed [16:0]    HL_P17 = 17'(HARD_LIMIT);
  localparam logic signed [16:0]    HL_N17 = -HL_P17;

  logic signed [15:0]    prev_r, prev_nxt;
  logic signed [POS_W:0] pos_x, prev_x, rate_x, up, dn, slewed, lim_v;
  logic signed [POS_W:0] lo_x, hi_x;
  logic signed [15:0]    servo;
  logic signed [16:0]    fs_sum, fs_lim;
  logic signed [15:0]    fs;

  // Slew, clamp and invert the position
  always_comb begin
    pos_x  = {mid_data.pos[POS_W-1], mid_data.pos};
    prev_x = {{(POS_W - 15){prev_r[15]}}, prev_r};
    rate_x = {{(POS_W + 1 - RATE_W){1'b0}}, mid_data.rate};
    up     = prev_x + rate_x;
    dn     = prev_x - rate_x;
    lo_x   = {{(POS_W - 15){cfg.limit_low[15]}}, cfg.limit_low};
    hi_x   = {{(POS_W - 15){cfg.limit_high[15]}}, cfg.limit_high};

    priority if (cfg.speed != 8'd0 && pos_x > up) begin
      slewed = up;
    end else if (cfg.speed != 8'd0 && pos_x < dn) begin
      slewed = dn;
    end else begin
      slewed = pos_x;
    end

    lim_v = slewed;
    if (lim_v < lo_x) begin
      lim_v = lo_x;
    end
    if (lim_v > hi_x) begin
      lim_v = hi_x;
    end
    if (lim_v < HL_N) begin
      lim_v = HL_N;
    end
    if (lim_v > HL_P) begin
      lim_v = HL_P;
    end

    prev_nxt = lim_v[15:0];
    servo    = cfg.invert_en ? 16'sd0 - prev_nxt : prev_nxt;
  end

  // Failsafe: subtrim plus position, hard clamp, invert
  always_comb begin
    fs_sum = {cfg.subtrim[15], cfg.subtrim} + {cfg.failsafe_pos[15], cfg.failsafe_pos};
    fs_lim = fs_sum;
    if (fs_lim < HL_N17) begin
      fs_lim = HL_N17;
    end
    if (fs_lim > HL_P17) begin
      fs_lim = HL_P17;
    end
    fs = cfg.invert_en ? 16'sd0 - fs_lim[15:0] : fs_lim[15:0];
  end

  assign out_data = '{servo_out: servo, failsafe_out: fs};

  // Hold the previous pre-inversion position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (take) begin
      prev_r <= prev_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/servo_endpoint_slew_limiter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted push passes the front stages, mid queue and result queue before
// empty goes low. One item per cycle unless stalled; the slew loop through the
// previous position closes in the back end, with all division pipelined ahead.
// Reset (rst_n low, synchronous): queues and pipeline emptied, previous
// position cleared to zero, configuration registers loaded with defaults.
// ----------------------------------------------------------------------------
// Servo end point / slew limiter core
// Front pipeline, queue, slew/clamp back end, output queue, config registers.
// ----------------------------------------------------------------------------
module servo_endpoint_slew_limiter_core
  import sesl_pkg::*;
#(
  parameter int FULL_SCALE = FULL_SCALE_DEF,
  parameter int HARD_LIMIT = HARD_LIMIT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input queue side
  input  wire logic        push,
  input  wire sesl_in_t    in_data,
  output logic             full,
  // Result queue side
  output logic             empty,
  input  wire logic        pop,
  output sesl_out_t        out_data,
  // Configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  sesl_cfg_t cfg_r, cfg_nxt;
  logic      mid_push, mid_empty, mid_take;
  sesl_mid_t mid_wdata, mid_rdata;
  logic [$bits(sesl_mid_t)-1:0] mid_rvec;
  logic      out_full;
  sesl_out_t back_word;
  logic [$bits(sesl_out_t)-1:0] out_rvec;

  assign cfg_ready = 1'b1;

  // Decode register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (sesl_reg_t'(cfg_index))
        REG_SUBTRIM:       cfg_nxt.subtrim       = cfg_wdata;
        REG_ENDPOINT_LOW:  cfg_nxt.endpoint_low  = cfg_wdata;
        REG_ENDPOINT_HIGH: cfg_nxt.endpoint_high = cfg_wdata[14:0];
        REG_SPEED:         cfg_nxt.speed         = cfg_wdata[7:0];
        REG_LIMIT_LOW:     cfg_nxt.limit_low     = cfg_wdata;
        REG_LIMIT_HIGH:    cfg_nxt.limit_high    = cfg_wdata;
        REG_FAILSAFE_POS:  cfg_nxt.failsafe_pos  = cfg_wdata;
        REG_INVERT_EN:     cfg_nxt.invert_en     = cfg_wdata[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: scaling and slew step
  sesl_front #(
    .FULL_SCALE (FULL_SCALE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .mid_pop  (mid_take),
    .full     (full),
    .mid_push (mid_push),
    .mid_data (mid_wdata)
  );

  // Queue between front and back
  sesl_fifo #(
    .DEPTH (MID_DEPTH),
    .WIDTH ($bits(sesl_mid_t))
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .pop   (mid_take),
    .rdata (mid_rvec),
    .empty (mid_empty),
    .full  ()
  );

  assign mid_rdata = mid_rvec;
  assign mid_take  = !mid_empty && !out_full;

  // Back end: slew against previous position, clamp, invert
  sesl_back #(
    .HARD_LIMIT (HARD_LIMIT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (mid_take),
    .mid_data (mid_rdata),
    .cfg      (cfg_r),
    .out_data (back_word)
  );

  // Result queue
  sesl_fifo #(
    .DEPTH (OUT_DEPTH),
    .WIDTH ($bits(sesl_out_t))
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_take),
    .wdata (back_word),
    .pop   (pop),
    .rdata (out_rvec),
    .empty (empty),
    .full  (out_full)
  );

  assign out_data = out_rvec;

endmodule
`default_nettype wire

### tb/servo_word_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo channel result checker
// Watches the input, result and register write channels of the servo end
// point / slew limiter. Keeps its own copy of the registers and the previous
// position, predicts each result word and compares it against the block.
// ----------------------------------------------------------------------------
module servo_word_checker
  import sesl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  sesl_in_t    in_data,
  input  logic        empty,
  input  logic        pop,
  input  sesl_out_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          outstanding
);

  sesl_cfg_t cfg_shadow;
  longint    last_pos;
  sesl_out_t servo_word_q[$];
  int        faults;

  initial begin
    fail_count  = 0;
    outstanding = 0;
    faults      = 0;
    cfg_shadow  = CFG_RESET;
    last_pos    = 0;
  end

  function automatic longint hard_clamp(input longint v);
    if (v < -longint'(HARD_LIMIT_DEF)) return -longint'(HARD_LIMIT_DEF);
    if (v > longint'(HARD_LIMIT_DEF)) return longint'(HARD_LIMIT_DEF);
    return v;
  endfunction

  // Scale, slew limit, clamp and invert one channel value
  function automatic sesl_out_t predict_servo(input sesl_in_t w, input longint prev,
                                              output longint next_pos);
    sesl_out_t r;
    longint    x;
    longint    span;
    longint    trim;
    longint    pos;
    longint    rate;
    longint    fs;
    x    = longint'($signed(w.channel_in));
    span = longint'(w.gap_ms);
    trim = longint'($signed(cfg_shadow.subtrim));
    if (x >= 0) begin
      pos = trim + (longint'(cfg_shadow.endpoint_high) * x) / FULL_SCALE_DEF;
    end else begin
      pos = trim + (longint'($signed(cfg_shadow.endpoint_low)) * x) / -FULL_SCALE_DEF;
    end
    // limit the step from the previous pre-inversion position
    if (cfg_shadow.speed != 0) begin
      rate = (longint'(FULL_SCALE_DEF) * longint'(cfg_shadow.speed)) / RATE_DIV_MIN;
      rate = (rate * span) / RATE_DIV_PCT;
      if (pos - prev > rate) begin
        pos = prev + rate;
      end else if (pos - prev < -rate) begin
        pos = prev - rate;
      end
    end
    // lower clamp first, so crossed limits leave the upper one
    if (pos < longint'($signed(cfg_shadow.limit_low))) pos = longint'($signed(cfg_shadow.limit_low));
    if (pos > longint'($signed(cfg_shadow.limit_high))) pos = longint'($signed(cfg_shadow.limit_high));
    pos      = hard_clamp(pos);
    next_pos = pos;
    fs = trim + longint'($signed(cfg_shadow.failsafe_pos));
    if (cfg_shadow.invert_en) begin
      pos = -pos;
      fs  = -fs;
    end
    r.servo_out    = 16'(hard_clamp(pos));
    r.failsafe_out = 16'(hard_clamp(fs));
    return r;
  endfunction

  task automatic log_fault(input string msg);
    faults++;
    if (faults <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    sesl_out_t want;
    sesl_out_t got;
    longint    next_pos;
    if (!rst_n) begin
      cfg_shadow = CFG_RESET;
      last_pos   = 0;
      servo_word_q.delete();
    end else begin
      // track register writes
      if (cfg_valid && cfg_ready) begin
        case (sesl_reg_t'(cfg_index))
          REG_SUBTRIM:       cfg_shadow.subtrim       = cfg_wdata;
          REG_ENDPOINT_LOW:  cfg_shadow.endpoint_low  = cfg_wdata;
          REG_ENDPOINT_HIGH: cfg_shadow.endpoint_high = cfg_wdata[14:0];
          REG_SPEED:         cfg_shadow.speed         = cfg_wdata[7:0];
          REG_LIMIT_LOW:     cfg_shadow.limit_low     = cfg_wdata;
          REG_LIMIT_HIGH:    cfg_shadow.limit_high    = cfg_wdata;
          REG_FAILSAFE_POS:  cfg_shadow.failsafe_pos  = cfg_wdata;
          REG_INVERT_EN:     cfg_shadow.invert_en     = cfg_wdata[0];
          default: ;
        endcase
      end
      // predict each accepted input word
      if (push && !full) begin
        want     = predict_servo(in_data, last_pos, next_pos);
        last_pos = next_pos;
        servo_word_q.push_back(want);
      end
      // compare each accepted result word with the oldest prediction
      if (pop && !empty) begin
        got = out_data;
        if (servo_word_q.size() == 0) begin
          log_fault($sformatf("result word %0d/%0d with nothing pending",
                              got.servo_out, got.failsafe_out));
        end else begin
          want = servo_word_q.pop_front();
          if (got.servo_out !== want.servo_out)
            log_fault($sformatf("servo_out expected %0d, got %0d",
                                want.servo_out, got.servo_out));
          if (got.failsafe_out !== want.failsafe_out)
            log_fault($sformatf("failsafe_out expected %0d, got %0d",
                                want.failsafe_out, got.failsafe_out));
        end
      end
    end
    outstanding <= servo_word_q.size();
    fail_count  <= faults;
  end

endmodule

### tb/servo_endpoint_slew_limiter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo end point / slew limiter testbench
// Drives directed corner words and randomized register settings and channel
// words through the core with random gaps on both sides; the checker beside
// the core predicts every result word and counts mismatches.
// ----------------------------------------------------------------------------
module servo_endpoint_slew_limiter_core_tb;
  import sesl_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int RAND_PHASES    = 10;
  localparam int PHASE_WORDS    = 75;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        push      = 1'b0;
  sesl_in_t    in_data   = '0;
  logic        full;
  logic        empty;
  logic        pop       = 1'b0;
  sesl_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        quiet     = 1'b0;
  int          fail_count;
  int          outstanding;

  always #(CLK_PERIOD / 2) clk = ~clk;

  servo_endpoint_slew_limiter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_data   (in_data),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  servo_word_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_data     (in_data),
    .empty       (empty),
    .pop         (pop),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Stall the result side at random unless in the quiet stretch
  always @(posedge clk) begin
    pop <= quiet || ($urandom_range(99) >= 23);
  end

  // Hard stop
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("*** FAILED ***");
    $finish;
  end

  // Hold one register write until the block takes it
  task automatic write_reg(input sesl_reg_t idx, input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_cfg(input sesl_cfg_t c);
    write_reg(REG_SUBTRIM, c.subtrim);
    write_reg(REG_ENDPOINT_LOW, c.endpoint_low);
    write_reg(REG_ENDPOINT_HIGH, {1'b0, c.endpoint_high});
    write_reg(REG_SPEED, {8'd0, c.speed});
    write_reg(REG_LIMIT_LOW, c.limit_low);
    write_reg(REG_LIMIT_HIGH, c.limit_high);
    write_reg(REG_FAILSAFE_POS, c.failsafe_pos);
    write_reg(REG_INVERT_EN, {15'd0, c.invert_en});
    cfg_valid <= 1'b0;
  endtask

  // Offer one word, at times with a random gap ahead of it outside the quiet stretch
  task automatic push_word(input logic [15:0] chan, input logic [15:0] span);
    if (!quiet && $urandom_range(99) < 15) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= '{channel_in: chan, gap_ms: span};
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Drop push, drain every pending result, then let the pipeline settle
  task automatic settle(input int tail);
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  function automatic int pick_span(input int lo, input int hi);
    int r;
    r = $urandom_range(99);
    if (r < 70) return lo + int'($urandom_range(hi - lo));
    if (r < 85) return $urandom_range(1) ? lo : hi;
    return int'($urandom_range(16'hFFFF)) - 32768;
  endfunction

  function automatic sesl_cfg_t random_setting();
    sesl_cfg_t c;
    int        a;
    int        b;
    int        t;
    int        r;
    c.subtrim       = 16'(pick_span(-4000, 4000));
    c.endpoint_low  = 16'(pick_span(-18000, 0));
    c.endpoint_high = 15'(pick_span(0, 18000));
    r = $urandom_range(99);
    if (r < 30) c.speed = 8'd0;
    else if (r < 70) c.speed = 8'($urandom_range(1, 8));
    else c.speed = 8'($urandom_range(255));
    // mostly ordered limits, now and then crossed
    a = pick_span(-18000, 18000);
    b = pick_span(-18000, 18000);
    if ($urandom_range(99) < 85 && a > b) begin
      t = a;
      a = b;
      b = t;
    end
    c.limit_low    = 16'(a);
    c.limit_high   = 16'(b);
    c.failsafe_pos = 16'(pick_span(-18000, 18000));
    c.invert_en    = 1'($urandom_range(1));
    return c;
  endfunction

  initial begin
    logic [15:0] chan;
    logic [15:0] span;
    int          r;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: input extremes, no slew
    push_word(16'sd0, 16'd0);
    push_word(16'sh7FFF, 16'd65535);
    push_word(16'sh8000, 16'd0);
    push_word(16'sd10000, 16'd1);
    push_word(-16'sd10000, 16'd65535);
    push_word(16'sd1, 16'd0);
    push_word(-16'sd1, 16'd0);
    settle(12);

    // register extremes: crossed limits, fastest slew, inverted
    apply_cfg('{subtrim: -16'sd18000, endpoint_low: -16'sd18000, endpoint_high: 15'd18000,
                speed: 8'd255, limit_low: 16'sd18000, limit_high: -16'sd18000,
                failsafe_pos: 16'sd18000, invert_en: 1'b1});
    push_word(16'sh7FFF, 16'd0);
    push_word(16'sh8000, 16'd65535);
    push_word(16'sd0, 16'd1);
    settle(12);

    // slowest slew from a large subtrim, zero end points
    apply_cfg('{subtrim: 16'sd18000, endpoint_low: 16'sd0, endpoint_high: 15'd0,
                speed: 8'd1, limit_low: -16'sd18000, limit_high: 16'sd18000,
                failsafe_pos: -16'sd18000, invert_en: 1'b0});
    push_word(16'sd10000, 16'd0);
    push_word(-16'sd10000, 16'd1);
    push_word(16'sd10000, 16'd10);
    push_word(16'sh8000, 16'd65535);
    settle(12);

    // out of range register values taken as their bits
    apply_cfg('{subtrim: 16'sh8000, endpoint_low: 16'sh7FFF, endpoint_high: 15'h7FFF,
                speed: 8'hFF, limit_low: 16'sh8000, limit_high: 16'sh7FFF,
                failsafe_pos: 16'sh8000, invert_en: 1'b1});
    push_word(16'sh8000, 16'd65535);
    push_word(16'sh7FFF, 16'd3);
    push_word(16'sd0, 16'd0);
    push_word(16'sd12345, 16'd100);
    settle(12);

    // random settings, each with a run of random words
    for (int p = 0; p < RAND_PHASES; p++) begin
      quiet <= (p == 3);
      apply_cfg(random_setting());
      for (int k = 0; k < PHASE_WORDS; k++) begin
        r = $urandom_range(99);
        chan = (r < 70) ? 16'(int'($urandom_range(22000)) - 11000)
                        : 16'($urandom_range(16'hFFFF));
        r = $urandom_range(99);
        if (r < 70) span = 16'($urandom_range(40));
        else if (r < 90) span = 16'($urandom_range(1000));
        else span = 16'($urandom_range(16'hFFFF));
        push_word(chan, span);
      end
      settle(12);
    end

    quiet <= 1'b0;
    settle(20);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
